// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== design/joykey_pkg.sv =====
// ----------------------------------------------------------------------------
// joykey_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package joykey_pkg;

    localparam int DIR_BITS = 16;
    localparam int DIR_AXES = DIR_BITS / 2;
    localparam int AXIS_IDX_W = $clog2(DIR_AXES);
    localparam int DIR_IDX_W = $clog2(DIR_BITS);
    localparam int THR_W = 15;

    localparam logic [THR_W-1:0] THR_RESET = 15'd4915;

    localparam logic [1:0] CMD_BUTTON = 2'd0;
    localparam logic [1:0] CMD_AXIS   = 2'd1;
    localparam logic [1:0] CMD_POLL   = 2'd2;

    typedef struct packed {
        logic cap_button;
        logic wr_axis;
        logic cap_poll;
        logic load_next;
    } t_dp_cmd;

    typedef struct packed {
        logic mask_empty;
        logic out_last;
    } t_dp_status;

endpackage

// ===== design/joykey_dp.sv =====
// ----------------------------------------------------------------------------
// joykey_dp
// axis store, threshold compare, change mask scan and output word register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joykey_dp
    import joykey_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic                    i_cfg_wr,
    input  logic [THR_W-1:0]        i_cfg_data,
    input  logic [7:0]              i_number,
    input  logic signed [15:0]      i_value,
    output logic                    o_kind,
    output logic [7:0]              o_key_index,
    output logic                    o_pressed,
    output logic                    o_last
);

    logic signed [15:0]     r_axis [DIR_AXES];
    logic [THR_W-1:0]       r_thr;
    logic [DIR_BITS-1:0]    r_prev;
    logic [DIR_BITS-1:0]    r_bits;
    logic [DIR_BITS-1:0]    r_mask;
    logic                   r_kind;
    logic [7:0]             r_key;
    logic                   r_pressed;
    logic                   r_last;

    logic [DIR_BITS-1:0]    n_bits;
    logic [DIR_IDX_W-1:0]   n_idx;
    logic [DIR_BITS-1:0]    n_mask;
    logic signed [16:0]     thr_pos;
    logic signed [16:0]     thr_neg;
    logic signed [16:0]     v_ext;

    // direction bits of the stored axes
    always_comb begin
        thr_pos = $signed({2'b00, r_thr});
        thr_neg = -thr_pos;
        n_bits  = '0;
        v_ext   = '0;
        for (int a = 0; a < DIR_AXES; a++) begin
            v_ext = {r_axis[a][15], r_axis[a]};
            if (v_ext < thr_neg) begin
                n_bits[2*a] = 1'b1;
            end else if (v_ext > thr_pos) begin
                n_bits[2*a+1] = 1'b1;
            end
        end
    end

    // lowest pending changed bit
    always_comb begin
        n_idx = '0;
        for (int b = DIR_BITS - 1; b >= 0; b--) begin
            if (r_mask[b]) begin
                n_idx = DIR_IDX_W'(b);
            end
        end
        n_mask = r_mask;
        n_mask[n_idx] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < DIR_AXES; a++) begin
                r_axis[a] <= '0;
            end
            r_thr  <= THR_RESET;
            r_prev <= '0;
            r_mask <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_thr <= i_cfg_data;
            end
            // axes 8 and up never drive keys, so they are not kept
            if (i_cmd.wr_axis && (i_number < 8'(DIR_AXES))) begin
                r_axis[i_number[AXIS_IDX_W-1:0]] <= i_value;
            end
            if (i_cmd.cap_poll) begin
                r_prev <= n_bits;
                r_mask <= n_bits ^ r_prev;
            end else if (i_cmd.load_next) begin
                r_mask <= n_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_poll) begin
            r_bits <= n_bits;
        end
        if (i_cmd.cap_button) begin
            r_kind    <= 1'b0;
            r_key     <= i_number;
            r_pressed <= |i_value;
            r_last    <= 1'b1;
        end else if (i_cmd.load_next) begin
            r_kind    <= 1'b1;
            r_key     <= 8'(n_idx);
            r_pressed <= r_bits[n_idx];
            r_last    <= ~|n_mask;
        end
    end

    assign o_status.mask_empty = ~|r_mask;
    assign o_status.out_last   = r_last;
    assign o_kind              = r_kind;
    assign o_key_index         = r_key;
    assign o_pressed           = r_pressed;
    assign o_last              = r_last;

endmodule

// ===== design/joykey_ctrl.sv =====
// ----------------------------------------------------------------------------
// joykey_ctrl
// controller: input decode, scan sequencing and output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module joykey_ctrl
    import joykey_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    output logic        o_valid,
    input  logic        i_ready,
    output t_dp_cmd     o_cmd,
    input  t_dp_status  i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;
    logic   in_acc;

    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        CMD_BUTTON: begin
                            o_cmd.cap_button = 1'b1;
                            n_valid          = 1'b1;
                            n_state          = S_OUT;
                        end
                        CMD_AXIS: begin
                            o_cmd.wr_axis = 1'b1;
                        end
                        CMD_POLL: begin
                            o_cmd.cap_poll = 1'b1;
                            n_state        = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_status.mask_empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.load_next = 1'b1;
                    n_valid         = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    if (i_status.out_last) begin
                        n_valid = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.load_next = 1'b1;
                    end
                end
            end
            default: begin
                n_valid = 1'b0;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    `ASSERT_NEVER(a_busy_both, i_clk, i_rst_n, o_valid && o_ready, "output and input both open")
    `ASSERT_CLK(a_button_out, i_clk, i_rst_n, (in_acc && (i_command == CMD_BUTTON)) |=> o_valid, "button word not presented")
    `ASSERT_CLK(a_axis_free, i_clk, i_rst_n, (in_acc && (i_command == CMD_AXIS)) |=> o_ready, "axis event stalled input")
    `ASSERT_CLK(a_last_done, i_clk, i_rst_n, (o_valid && i_ready && i_status.out_last) |=> !o_valid, "word after last")

endmodule

// ===== design/joystick_axis_to_key_events_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_to_key_events_unit
// joystick button, axis and poll events to key press/release words
// ----------------------------------------------------------------------------
// input channel (i_valid/o_ready) takes one event word: a button event gives
// one key word, an axis event stores the position of axes 0 to 7, a poll
// tick compares direction bits of those axes against the last poll and gives
// one key word per changed bit, lowest bit first, the final one with o_last.
// output channel (o_valid/i_ready) comes from a register.
// sequence: an axis event leaves the input ready. a button event is shown the cycle
// after acceptance. a poll captures the bits, then starts the scan in S_SCAN,
// then gives one key word per cycle while i_ready stays high; a poll with no
// change returns from S_SCAN to idle. the change mask scan gives up to 16
// words per poll.
// a new event is taken only once all words of the last one are delivered.
// a stalled receiver holds the current word and the scan.
// reset clears stored axes, last poll bits, sets threshold to 4915.
// config port (i_cfg_valid/o_cfg_ready) is always ready; write while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_axis_to_key_events_unit
    import joykey_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_command,
    input  logic [7:0]          i_number,
    input  logic signed [15:0]  i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_kind,
    output logic [7:0]          o_key_index,
    output logic                o_pressed,
    output logic                o_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [THR_W-1:0]    i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    joykey_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_cmd     (dp_cmd),
        .i_status  (dp_status)
    );

    joykey_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_number    (i_number),
        .i_value     (i_value),
        .o_kind      (o_kind),
        .o_key_index (o_key_index),
        .o_pressed   (o_pressed),
        .o_last      (o_last)
    );

endmodule
